### rtl/core/rosi_pkg.sv
// Shared types, constants and helper functions for the ray and oriented box slab test.
// It has no dependencies. The front end, the divider cells, the back end and the top level use it.
`default_nettype none
package rosi_pkg;
	localparam int COORD_BITS = 16;
	localparam int DIST_BITS = 32;
	localparam int VEC_BITS = 3 * COORD_BITS;
	localparam int FRAC_SHIFT = 22;
	localparam int MAG_BITS = 34;
	localparam int NUM_BITS = MAG_BITS + FRAC_SHIFT;
	localparam int DVS_BITS = 32;
	localparam int DIV_STEPS = NUM_BITS;
	localparam int T_BITS = NUM_BITS + 2;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HALF      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ONE  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_TWO  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_THR  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd5;

	localparam logic signed [T_BITS-1:0] T_NEG_INF = {1'b1, {(T_BITS-1){1'b0}}};
	localparam logic signed [T_BITS-1:0] T_POS_INF = {1'b0, {(T_BITS-1){1'b1}}};

	typedef struct packed {
		logic [VEC_BITS-1:0] center;
		logic [VEC_BITS-1:0] half;
		logic [2:0][VEC_BITS-1:0] axis;
		logic [15:0] thr;
	} cfg_t;

	typedef struct packed {
		logic neg;
		logic [DVS_BITS-1:0] rem;
		logic [NUM_BITS-1:0] dq;
	} lane_t;

	typedef struct packed {
		logic par;
		logic pmiss;
		logic [DVS_BITS-1:0] dvs;
		lane_t lo;
		lane_t hi;
	} axis_t;

	typedef struct packed {
		axis_t [2:0] ax;
		logic signed [DIST_BITS-1:0] wmin;
		logic signed [DIST_BITS-1:0] wmax;
	} ctx_t;

	function automatic logic signed [COORD_BITS-1:0] comp(input logic [VEC_BITS-1:0] v,
		input int k);
		return $signed(v[k*COORD_BITS +: COORD_BITS]);
	endfunction

	function automatic lane_t div_step(input lane_t l, input logic [DVS_BITS-1:0] dvs);
		logic [DVS_BITS:0] tr;
		logic [DVS_BITS:0] df;
		lane_t o;
		tr = {l.rem, l.dq[NUM_BITS-1]};
		df = tr - {1'b0, dvs};
		o = l;
		if (!df[DVS_BITS]) begin
			o.rem = df[DVS_BITS-1:0];
			o.dq = {l.dq[NUM_BITS-2:0], 1'b1};
		end else begin
			o.rem = tr[DVS_BITS-1:0];
			o.dq = {l.dq[NUM_BITS-2:0], 1'b0};
		end
		return o;
	endfunction
endpackage
`default_nettype wire

### rtl/core/rosi_front.sv
// Front end of the slab test: offsets, dot products, parallel check and slab numerators.
// It depends on rosi_pkg and feeds the divider cell chain.
`default_nettype none
module rosi_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] org [3],
	input  wire logic [rosi_pkg::COORD_BITS-1:0] dir [3],
	input  wire logic [rosi_pkg::DIST_BITS-1:0] wmin,
	input  wire logic [rosi_pkg::DIST_BITS-1:0] wmax,
	input  wire rosi_pkg::cfg_t cfg,
	output logic v_out,
	output rosi_pkg::ctx_t ctx_out
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [rosi_pkg::COORD_BITS:0] diff_s1 [3];
	logic signed [rosi_pkg::COORD_BITS-1:0] dir_s1 [3];
	logic signed [rosi_pkg::DIST_BITS-1:0] wmin_s1, wmax_s1, wmin_s2, wmax_s2;
	logic signed [rosi_pkg::DIST_BITS-1:0] wmin_s3, wmax_s3;
	logic signed [32:0] pr_s2 [3][3];
	logic signed [31:0] ps_s2 [3][3];
	logic signed [rosi_pkg::COORD_BITS-1:0] h_s2 [3];
	logic signed [34:0] r_s3 [3];
	logic signed [33:0] s_s3 [3];
	logic signed [29:0] h_s3 [3];
	rosi_pkg::ctx_t ctx_d;
	rosi_pkg::ctx_t ctx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				diff_s1[k] <= 17'(rosi_pkg::comp(cfg.center, k)) - 17'($signed(org[k]));
				dir_s1[k] <= $signed(dir[k]);
			end
			wmin_s1 <= $signed(wmin);
			wmax_s1 <= $signed(wmax);
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pr_s2[i][k] <= rosi_pkg::comp(cfg.axis[i], k) * diff_s1[k];
					ps_s2[i][k] <= rosi_pkg::comp(cfg.axis[i], k) * dir_s1[k];
				end
				h_s2[i] <= rosi_pkg::comp(cfg.half, i);
			end
			wmin_s2 <= wmin_s1;
			wmax_s2 <= wmax_s1;
			for (int i = 0; i < 3; i++) begin
				r_s3[i] <= 35'(pr_s2[i][0]) + 35'(pr_s2[i][1]) + 35'(pr_s2[i][2]);
				s_s3[i] <= 34'(ps_s2[i][0]) + 34'(ps_s2[i][1]) + 34'(ps_s2[i][2]);
				h_s3[i] <= {h_s2[i], 14'b0};
			end
			wmin_s3 <= wmin_s2;
			wmax_s3 <= wmax_s2;
			ctx_s4 <= ctx_d;
		end
	end

	always_comb begin
		logic signed [35:0] hx, rx, lo, hi;
		logic [33:0] abs_s, thr_x, mlo, mhi;
		ctx_d = '0;
		for (int i = 0; i < 3; i++) begin
			abs_s = s_s3[i][33] ? 34'(-s_s3[i]) : 34'(s_s3[i]);
			thr_x = {4'b0, cfg.thr, 14'b0};
			hx = 36'(h_s3[i]);
			rx = 36'(r_s3[i]);
			lo = rx + hx;
			hi = rx - hx;
			mlo = lo[35] ? 34'(-lo) : 34'(lo);
			mhi = hi[35] ? 34'(-hi) : 34'(hi);
			ctx_d.ax[i].par = (s_s3[i] == '0) || (abs_s < thr_x);
			ctx_d.ax[i].pmiss = ctx_d.ax[i].par && ((rx > hx) || (rx < -hx));
			ctx_d.ax[i].dvs = abs_s[rosi_pkg::DVS_BITS-1:0];
			ctx_d.ax[i].lo.neg = lo[35] ^ s_s3[i][33];
			ctx_d.ax[i].lo.rem = '0;
			ctx_d.ax[i].lo.dq = {mlo, {rosi_pkg::FRAC_SHIFT{1'b0}}};
			ctx_d.ax[i].hi.neg = hi[35] ^ s_s3[i][33];
			ctx_d.ax[i].hi.rem = '0;
			ctx_d.ax[i].hi.dq = {mhi, {rosi_pkg::FRAC_SHIFT{1'b0}}};
		end
		ctx_d.wmin = wmin_s3;
		ctx_d.wmax = wmax_s3;
	end

	assign v_out = v_s4;
	assign ctx_out = ctx_s4;
endmodule
`default_nettype wire

### rtl/core/rosi_div_cell.sv
// One cell of the divider chain: a single restoring step for all six slab quotients.
// It depends on rosi_pkg and passes the whole item context to the next cell.
`default_nettype none
module rosi_div_cell (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic v_in,
	input  wire rosi_pkg::ctx_t ctx_in,
	output logic v_out,
	output rosi_pkg::ctx_t ctx_out
);
	logic v_q;
	rosi_pkg::ctx_t ctx_q;
	rosi_pkg::ctx_t ctx_d;

	always_comb begin
		ctx_d = ctx_in;
		for (int i = 0; i < 3; i++) begin
			ctx_d.ax[i].lo = rosi_pkg::div_step(ctx_in.ax[i].lo, ctx_in.ax[i].dvs);
			ctx_d.ax[i].hi = rosi_pkg::div_step(ctx_in.ax[i].hi, ctx_in.ax[i].dvs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_d;
		end
	end

	assign v_out = v_q;
	assign ctx_out = ctx_q;
endmodule
`default_nettype wire

### rtl/core/rosi_back.sv
// Back end of the slab test: signed slab distances, interval folding, clamp and window check.
// It depends on rosi_pkg and holds the output register.
`default_nettype none
module rosi_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic v_in,
	input  wire rosi_pkg::ctx_t ctx_in,
	output logic out_valid,
	output logic hit,
	output logic [rosi_pkg::DIST_BITS-2:0] hit_distance
);
	logic v_b1, v_b2, v_q;
	logic signed [rosi_pkg::T_BITS-1:0] tlo_b1 [3];
	logic signed [rosi_pkg::T_BITS-1:0] thi_b1 [3];
	logic [2:0] par_b1;
	logic pmiss_b1, pmiss_b2;
	logic signed [rosi_pkg::DIST_BITS-1:0] wmin_b1, wmax_b1, wmin_b2, wmax_b2;
	logic signed [rosi_pkg::T_BITS-1:0] near_b2, far_b2, near_d, far_d;
	logic hit_q;
	logic [rosi_pkg::DIST_BITS-2:0] dist_q;
	logic hit_d;
	logic [rosi_pkg::DIST_BITS-2:0] dist_d;

	always_comb begin
		near_d = rosi_pkg::T_NEG_INF;
		far_d = rosi_pkg::T_POS_INF;
		for (int i = 0; i < 3; i++) begin
			if (!par_b1[i]) begin
				if (tlo_b1[i] > near_d) near_d = tlo_b1[i];
				if (thi_b1[i] < far_d) far_d = thi_b1[i];
			end
		end
	end

	always_comb begin
		logic signed [rosi_pkg::T_BITS-1:0] d;
		logic signed [rosi_pkg::DIST_BITS:0] dx;
		logic miss;
		miss = pmiss_b2 || (far_b2 < 0) || (near_b2 > far_b2);
		d = (near_b2 > 0) ? near_b2 : far_b2;
		if (d < 0) begin
			dist_d = '0;
		end else if (d > rosi_pkg::T_BITS'({(rosi_pkg::DIST_BITS-1){1'b1}})) begin
			dist_d = '1;
		end else begin
			dist_d = d[rosi_pkg::DIST_BITS-2:0];
		end
		dx = $signed({2'b00, dist_d});
		hit_d = !miss && (dx >= 33'(wmin_b2)) && (dx <= 33'(wmax_b2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_q <= 1'b0;
		end else if (en) begin
			v_b1 <= v_in;
			v_b2 <= v_b1;
			v_q <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [rosi_pkg::T_BITS-1:0] a, b;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a = $signed({2'b00, ctx_in.ax[i].lo.dq});
				b = $signed({2'b00, ctx_in.ax[i].hi.dq});
				if (ctx_in.ax[i].lo.neg) a = -a;
				if (ctx_in.ax[i].hi.neg) b = -b;
				tlo_b1[i] <= (a > b) ? b : a;
				thi_b1[i] <= (a > b) ? a : b;
				par_b1[i] <= ctx_in.ax[i].par;
			end
			pmiss_b1 <= ctx_in.ax[0].pmiss | ctx_in.ax[1].pmiss | ctx_in.ax[2].pmiss;
			wmin_b1 <= ctx_in.wmin;
			wmax_b1 <= ctx_in.wmax;
			near_b2 <= near_d;
			far_b2 <= far_d;
			pmiss_b2 <= pmiss_b1;
			wmin_b2 <= wmin_b1;
			wmax_b2 <= wmax_b1;
			hit_q <= hit_d;
			dist_q <= hit_d ? dist_d : '0;
		end
	end

	assign out_valid = v_q;
	assign hit = hit_q;
	assign hit_distance = dist_q;
endmodule
`default_nettype wire

### rtl/core/ray_obb_slab_intersect.sv
// Ray against oriented box slab test: one item per cycle while no result waits on the output.
// The pipeline has 4 front stages, 56 divider cells (one quotient bit each) and 3 back stages.
// The whole pipeline holds while a result waits on the output; in_ready is low only then.
// Reset clears all valid flags and loads the box registers with the unit axes and threshold 1.
// Depends on rosi_pkg, rosi_front, rosi_div_cell and rosi_back.
`default_nettype none
module ray_obb_slab_intersect (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [rosi_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [rosi_pkg::VEC_BITS-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] origin_x,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] origin_y,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] origin_z,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] dir_x,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] dir_y,
	input  wire logic [rosi_pkg::COORD_BITS-1:0] dir_z,
	input  wire logic [rosi_pkg::DIST_BITS-1:0] window_min,
	input  wire logic [rosi_pkg::DIST_BITS-1:0] window_max,
	output logic out_valid,
	input  wire logic out_ready,
	output logic hit,
	output logic [rosi_pkg::DIST_BITS-2:0] hit_distance
);
	rosi_pkg::cfg_t cfg_q;
	logic en;
	logic [rosi_pkg::COORD_BITS-1:0] org [3];
	logic [rosi_pkg::COORD_BITS-1:0] dir [3];
	logic v_chain [rosi_pkg::DIV_STEPS+1];
	rosi_pkg::ctx_t ctx_chain [rosi_pkg::DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center <= '0;
			cfg_q.half <= '0;
			cfg_q.axis[0] <= 48'h0000_0000_4000;
			cfg_q.axis[1] <= 48'h0000_4000_0000;
			cfg_q.axis[2] <= 48'h4000_0000_0000;
			cfg_q.thr <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				rosi_pkg::REG_CENTER: cfg_q.center <= cfg_data;
				rosi_pkg::REG_HALF: cfg_q.half <= cfg_data;
				rosi_pkg::REG_AXIS_ONE: cfg_q.axis[0] <= cfg_data;
				rosi_pkg::REG_AXIS_TWO: cfg_q.axis[1] <= cfg_data;
				rosi_pkg::REG_AXIS_THR: cfg_q.axis[2] <= cfg_data;
				rosi_pkg::REG_THRESHOLD: cfg_q.thr <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	rosi_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.org(org), .dir(dir), .wmin(window_min), .wmax(window_max), .cfg(cfg_q),
		.v_out(v_chain[0]), .ctx_out(ctx_chain[0])
	);

	for (genvar g = 0; g < rosi_pkg::DIV_STEPS; g++) begin : g_cell
		rosi_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(v_chain[g]), .ctx_in(ctx_chain[g]),
			.v_out(v_chain[g+1]), .ctx_out(ctx_chain[g+1])
		);
	end

	rosi_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_in(v_chain[rosi_pkg::DIV_STEPS]), .ctx_in(ctx_chain[rosi_pkg::DIV_STEPS]),
		.out_valid(out_valid), .hit(hit), .hit_distance(hit_distance)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_distance == '0)
		else $error("miss result carries a nonzero distance");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance))
		else $error("waiting result changed before its transfer");
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for ray_obb_slab_intersect: directed and random rays against configured boxes.
// Checks each result against a slab-test predictor in this file. Depends on rosi_pkg and the RTL.
`default_nettype none
module tb_top;
	typedef struct {
		logic signed [15:0] ox, oy, oz, dx, dy, dz;
		logic signed [31:0] wmin, wmax;
	} ray_t;

	typedef struct {
		logic hit;
		logic [30:0] distance;
	} hit_t;

	typedef struct {
		ray_t r;
		logic chk;
		hit_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rosi_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [rosi_pkg::VEC_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [31:0] window_min = '0, window_max = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [30:0] hit_distance;

	logic [47:0] cur_center, cur_half, cur_thr;
	logic [47:0] cur_axis[3];
	hit_t pending_hits[$];
	int errors = 0;
	int n_items = 0;
	int n_hits = 0;
	int n_results = 0;
	int hold_cycles = 0;
	int stall_mode = 0;

	ray_obb_slab_intersect i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#60000000;
		$display("Timeout at %0t", $time);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint comp_of(input logic [47:0] v, input int k);
		logic signed [15:0] c;
		c = v[k*16 +: 16];
		return longint'(c);
	endfunction

	function automatic hit_t slab_hit(input ray_t r);
		longint org[3], dv[3];
		longint tn, tf, rr, ss, h, abs_s, t0, t1, tmp, d_val, a;
		logic miss;
		hit_t o;
		org[0] = longint'(r.ox); org[1] = longint'(r.oy); org[2] = longint'(r.oz);
		dv[0] = longint'(r.dx); dv[1] = longint'(r.dy); dv[2] = longint'(r.dz);
		tn = 64'sh8000000000000000;
		tf = 64'sh7fffffffffffffff;
		miss = 1'b0;
		for (int i = 0; i < 3 && !miss; i++) begin
			rr = 0;
			ss = 0;
			for (int k = 0; k < 3; k++) begin
				a = comp_of(cur_axis[i], k);
				rr += a * (comp_of(cur_center, k) - org[k]);
				ss += a * dv[k];
			end
			h = comp_of(cur_half, i) * 16384;
			abs_s = (ss < 0) ? -ss : ss;
			if (ss == 0 || abs_s < longint'(cur_thr) * 16384) begin
				if (rr > h || rr < -h)
					miss = 1'b1;
				continue;
			end
			t0 = ((rr + h) * (longint'(1) << 22)) / ss;
			t1 = ((rr - h) * (longint'(1) << 22)) / ss;
			if (t0 > t1) begin
				tmp = t0;
				t0 = t1;
				t1 = tmp;
			end
			if (t0 > tn)
				tn = t0;
			if (t1 < tf)
				tf = t1;
			if (tf < 0)
				miss = 1'b1;
		end
		if (!miss && tn > tf)
			miss = 1'b1;
		o.hit = 1'b0;
		o.distance = '0;
		if (!miss) begin
			d_val = (tn > 0) ? tn : tf;
			if (d_val < 0)
				d_val = 0;
			if (d_val > 64'h7fffffff)
				d_val = 64'h7fffffff;
			if (d_val >= longint'(r.wmin) && d_val <= longint'(r.wmax)) begin
				o.hit = 1'b1;
				o.distance = d_val[30:0];
			end
		end
		return o;
	endfunction

	task automatic write_reg(input logic [rosi_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rosi_pkg::REG_CENTER: cur_center = val;
			rosi_pkg::REG_HALF: cur_half = val;
			rosi_pkg::REG_AXIS_ONE: cur_axis[0] = val;
			rosi_pkg::REG_AXIS_TWO: cur_axis[1] = val;
			rosi_pkg::REG_AXIS_THR: cur_axis[2] = val;
			rosi_pkg::REG_THRESHOLD: cur_thr = {32'd0, val[15:0]};
			default: ;
		endcase
	endtask

	// Called at a falling edge; the sender goes idle and waits for all results.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send_ray(input ray_t r, input logic chk, input hit_t res);
		hit_t p;
		p = slab_hit(r);
		if (chk && (p.hit != res.hit || p.distance != res.distance)) begin
			$display("%0t predictor disagrees with table: expected %0b/%0d got %0b/%0d",
				$time, res.hit, res.distance, p.hit, p.distance);
			errors++;
		end
		in_valid <= 1'b1;
		origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
		dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
		window_min <= r.wmin; window_max <= r.wmax;
		do @(posedge clk); while (!in_ready);
		pending_hits.push_back(p);
		n_items++;
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 1) ? 0 : -1);
			3: return 16'($signed($urandom_range(0, 2048)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic ray_t rnd_ray(input logic aimed);
		ray_t r;
		r.ox = rnd16(); r.oy = rnd16(); r.oz = rnd16();
		r.dx = rnd16(); r.dy = rnd16(); r.dz = rnd16();
		if (aimed) begin
			r.ox = 16'(comp_of(cur_center, 0) - longint'($urandom_range(0, 4000)));
			r.oy = 16'(comp_of(cur_center, 1) + longint'($urandom_range(0, 400)) - 200);
			r.oz = 16'(comp_of(cur_center, 2) + longint'($urandom_range(0, 400)) - 200);
			r.dx = 16'($urandom_range(4096, 16384));
			r.dy = 16'($signed($urandom_range(0, 2000)) - 1000);
			r.dz = 16'($signed($urandom_range(0, 2000)) - 1000);
		end
		case ($urandom_range(0, 3))
			0: begin r.wmin = 32'sh80000000; r.wmax = 32'sh7fffffff; end
			1: begin r.wmin = 32'($urandom); r.wmax = 32'($urandom); end
			default: begin
				r.wmin = 32'($urandom_range(0, 1 << 22));
				r.wmax = r.wmin + 32'($urandom_range(0, 1 << 26));
			end
		endcase
		return r;
	endfunction

	function automatic logic [47:0] rnd_axis();
		case ($urandom_range(0, 3))
			0: return {32'd0, 16'd16384};
			1: return {16'd0, 16'd16384, 16'd0};
			2: return {16'd11585, 16'd0, 16'd11585};
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	// Receiver: random stalls, bursts of full readiness and one long hold-off.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					stall_mode = $urandom_range(0, 2);
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_hits.size() == 0) begin
				$display("%0t unexpected result hit=%0b distance=%0d", $time, hit, hit_distance);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				if (hit !== e.hit) begin
					$display("%0t hit expected %0b actual %0b", $time, e.hit, hit);
					errors++;
				end
				if (hit_distance !== e.distance) begin
					$display("%0t hit_distance expected %0d actual %0d", $time, e.distance,
						hit_distance);
					errors++;
				end
				if (hit === 1'b1)
					n_hits++;
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t w;
		ray_t r;
		hit_t m, sat;
		int burst;
		int gap;
		cur_center = '0;
		cur_half = '0;
		cur_axis[0] = 48'd16384;
		cur_axis[1] = 48'd16384 << 16;
		cur_axis[2] = 48'd16384 << 32;
		cur_thr = 48'd1;
		m.hit = 1'b0;
		m.distance = '0;
		sat.hit = 1'b1;
		sat.distance = 31'h7fffffff;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset box has zero extents: an origin at the center with zero direction
		// is parallel everywhere and saturates; any other origin misses.
		w.r = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sh80000000, 32'sh7fffffff};
		w.chk = 1'b1; w.res = sat; rows.push_back(w);
		w.r.ox = 16'sh7fff; w.res = m; rows.push_back(w);
		w.r.ox = 16'sh8000; rows.push_back(w);
		w.r = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd5, 32'sd4};
		rows.push_back(w);
		foreach (rows[i])
			send_ray(rows[i].r, rows[i].chk, rows[i].res);
		drain();

		write_reg(rosi_pkg::REG_CENTER, {16'sd0, 16'sd0, 16'sd2560});
		write_reg(rosi_pkg::REG_HALF, {16'sd256, 16'sd256, 16'sd256});
		write_reg(rosi_pkg::REG_THRESHOLD, 48'd0);
		write_reg(3'd7, 48'hffffffffffff);
		rows.delete();
		w.chk = 1'b0; w.res = m;
		w.r = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sh80000000,
			32'sh7fffffff};
		rows.push_back(w);
		w.r.dx = -16'sd16384; rows.push_back(w);
		w.r.dx = 16'sh8000; rows.push_back(w);
		w.r.dx = 16'sh7fff; w.r.dy = 16'sh7fff; w.r.dz = 16'sh8000; rows.push_back(w);
		w.r.ox = 16'sd2560; rows.push_back(w);
		w.r = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd0};
		rows.push_back(w);
		w.r = '{16'sd0, 16'sd512, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sh80000000,
			32'sh7fffffff};
		w.chk = 1'b1; rows.push_back(w);
		w.r.oy = 16'sh8000; w.r.dy = 16'sd1; w.chk = 1'b0; rows.push_back(w);
		w.r = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sh7fffffff,
			32'sh80000000};
		w.chk = 1'b1; rows.push_back(w);
		foreach (rows[i])
			send_ray(rows[i].r, rows[i].chk, rows[i].res);
		drain();

		write_reg(rosi_pkg::REG_HALF, {16'sh8000, 16'sh8000, 16'sh8000});
		write_reg(rosi_pkg::REG_THRESHOLD, 48'hffff);
		send_ray('{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sh80000000,
			32'sh7fffffff}, 1'b1, m);
		drain();
		write_reg(rosi_pkg::REG_HALF, {16'sh7fff, 16'sh7fff, 16'sh7fff});
		write_reg(rosi_pkg::REG_THRESHOLD, 48'd1);
		send_ray('{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1, 32'sh80000000,
			32'sh7fffffff}, 1'b0, m);
		send_ray('{16'sh8000, 16'sh8000, 16'sh8000, 16'sd1, 16'sd0, 16'sd0, 32'sh80000000,
			32'sh7fffffff}, 1'b0, m);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0) begin
				write_reg(rosi_pkg::REG_CENTER, 48'd0);
				write_reg(rosi_pkg::REG_HALF, {16'sd1024, 16'sd768, 16'sd512});
				write_reg(rosi_pkg::REG_AXIS_ONE, 48'd16384);
				write_reg(rosi_pkg::REG_AXIS_TWO, 48'd16384 << 16);
				write_reg(rosi_pkg::REG_AXIS_THR, 48'd16384 << 32);
				write_reg(rosi_pkg::REG_THRESHOLD, 48'd1);
			end else begin
				write_reg(rosi_pkg::REG_CENTER, {16'($urandom_range(0, 4096)),
					16'($urandom_range(0, 4096)), 16'($urandom)});
				write_reg(rosi_pkg::REG_HALF, (phase == 7) ? 48'({$urandom, $urandom}) :
					{16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
					16'($urandom_range(1, 3000))});
				write_reg(rosi_pkg::REG_AXIS_ONE, rnd_axis());
				write_reg(rosi_pkg::REG_AXIS_TWO, rnd_axis());
				write_reg(rosi_pkg::REG_AXIS_THR, rnd_axis());
				write_reg(rosi_pkg::REG_THRESHOLD, (phase == 5) ? 48'hffff :
					48'($urandom_range(0, 64)));
			end
			if (phase == 2)
				hold_cycles = 300;
			for (int n = 0; n < 200; n += burst) begin
				burst = $urandom_range(1, 30);
				for (int b = 0; b < burst; b++) begin
					r = rnd_ray($urandom_range(0, 3) != 0);
					send_ray(r, 1'b0, m);
				end
				gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
				if (phase == 4 && n < 100 && n + burst >= 100) begin
					in_valid <= 1'b0;
					while (pending_hits.size() != 0)
						@(negedge clk);
				end else if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			drain();
		end

		$display("Sent %0d rays over eight box settings plus directed cases; %0d results, %0d hits.",
			n_items, n_results, n_hits);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
rtl/core/rosi_pkg.sv
rtl/core/rosi_front.sv
rtl/core/rosi_div_cell.sv
rtl/core/rosi_back.sv
rtl/core/ray_obb_slab_intersect.sv
tb/tb_top.sv
